// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, left empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- hdl/pctd_pkg.sv -----
// ---------------------------------------------------------------------------
// Percent decoder package
// Beat types, the job passed from front to back, characters and hex helpers.
// ---------------------------------------------------------------------------
package pctd_pkg;

  // characters of interest
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // largest number of decoded bytes one input beat can give
  localparam int unsigned MAX_OUT = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // decoded bytes of one input beat, first byte in entry 0
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] job_bytes;
    logic [1:0]              cnt;
    logic                    last;
  } job_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // value of a hex digit character; letters carry 1..6 in the low nibble
  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [3:0] v;
    if (c[6]) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

endpackage

// ----- hdl/pctd_front.sv -----
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Percent decoder front end
// Accepts encoded beats, tracks the escape state and builds a job of up to
// three decoded bytes for the queue.
// ---------------------------------------------------------------------------
module pctd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pctd_pkg::in_beat_t in_data,
  input  logic              q_full,
  output logic              push,
  output pctd_pkg::job_t    job
);
  import pctd_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  logic       do_plain;
  logic       b_hex;
  logic [7:0] b;
  logic [1:0] n;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_data.in_byte;
  assign b_hex    = is_hex(b);

  // classify the beat and collect its output bytes
  always_comb begin
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    do_plain      = 1'b0;
    n             = 2'd0;
    job.job_bytes = '0;
    unique case (phase_r)
      PH_PCT: begin
        if (b_hex) begin
          held_nxt  = b;
          phase_nxt = PH_DIG;
        end else begin
          job.job_bytes[n] = CH_PERCENT;
          n         = n + 2'd1;
          phase_nxt = PH_IDLE;
          do_plain  = 1'b1;
        end
      end
      PH_DIG: begin
        if (b_hex) begin
          job.job_bytes[n] = {hex_nibble(held_r), hex_nibble(b)};
          n = n + 2'd1;
        end else begin
          job.job_bytes[n] = CH_PERCENT;
          n = n + 2'd1;
          job.job_bytes[n] = held_r;
          n = n + 2'd1;
          do_plain = 1'b1;
        end
        phase_nxt = PH_IDLE;
        held_nxt  = 8'h00;
      end
      default: begin
        phase_nxt = PH_IDLE;
        do_plain  = 1'b1;
      end
    endcase

    // ordinary byte handling, also for a byte that broke an escape
    if (do_plain) begin
      if (b == CH_PERCENT) begin
        phase_nxt = PH_PCT;
      end else if (b == CH_PLUS) begin
        job.job_bytes[n] = CH_SPACE;
        n = n + 2'd1;
      end else begin
        job.job_bytes[n] = b;
        n = n + 2'd1;
      end
    end

    // end of string: flush whatever is held
    if (in_data.in_last) begin
      if (phase_nxt == PH_PCT) begin
        job.job_bytes[n] = CH_PERCENT;
        n = n + 2'd1;
      end else if (phase_nxt == PH_DIG) begin
        job.job_bytes[n] = CH_PERCENT;
        n = n + 2'd1;
        job.job_bytes[n] = held_nxt;
        n = n + 2'd1;
      end
      phase_nxt = PH_IDLE;
      held_nxt  = 8'h00;
    end

    job.cnt  = n;
    job.last = in_data.in_last;
  end

  // beats that only open an escape give no job
  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  `ASSERT_HOLDS(a_last_clears, clk, rst_n, (accept && in_data.in_last) |=> (phase_r == PH_IDLE))
  `ASSERT_NEVER(a_last_empty, clk, rst_n, accept && in_data.in_last && !push)

endmodule

// ----- hdl/pctd_queue.sv -----
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Percent decoder job queue
// Small FIFO of jobs between front and back end.
// ---------------------------------------------------------------------------
module pctd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pctd_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output pctd_pkg::job_t head
);
  import pctd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == FULL_CNT);
  assign q_valid = (count_r != '0);
  assign head    = slots_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst_n, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !q_valid)

endmodule

// ----- hdl/pctd_back.sv -----
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Percent decoder back end
// Walks head job bytes into the output register, one beat a cycle unless stalled.
// ---------------------------------------------------------------------------
module pctd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pctd_pkg::job_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pctd_pkg::out_beat_t out_data
);
  import pctd_pkg::*;

  logic      [1:0] idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_beat_t       out_data_r, out_data_nxt;
  logic            load;
  logic            at_end;

  // output register is free when empty or being taken
  assign load   = !out_valid_r || !out_stall;
  assign at_end = (idx_r == head.cnt - 2'd1);

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = q_valid;
      if (q_valid) begin
        out_data_nxt.out_byte = head.job_bytes[idx_r];
        out_data_nxt.out_last = head.last && at_end;
        pop     = at_end;
        idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_idx_range, clk, rst_n, q_valid && (idx_r >= head.cnt))

endmodule

// ----- hdl/percent_decoder.sv -----
// Percent decoder: decodes a URL form-encoded byte stream, taking one encoded
// byte per cycle unless in_stall is raised by a full queue, and giving zero to
// three decoded bytes for it ('+' becomes a space, '%' with two hex digits
// becomes that byte, a broken escape is passed through literally and in_last
// flushes anything held, marking the final decoded byte). The front end
// classifies each beat combinationally and hands a job to a small queue; the
// back end puts out one decoded byte per cycle while out_stall is low, and
// the rare beats giving two or three bytes hold the output side while the
// queue (QUEUE_DEPTH jobs) keeps taking input. An input beat passes through
// a queue slot and then the output register on its way to the output.
// ---------------------------------------------------------------------------
// Percent decoder top level
// Front end, job queue and back end of the URL form decoder.
// ---------------------------------------------------------------------------
module percent_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pctd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pctd_pkg::out_beat_t out_data
);
  import pctd_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  job_t wr_job;
  job_t head;

  pctd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .job      (wr_job)
  );

  pctd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_job  (wr_job),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head)
  );

  pctd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
